// File: src/pbqe_pkg.sv
package pbqe_pkg;

   localparam int TILE_BITS = 16;

   localparam logic [16:0] POLY_A  = 17'd102944;
   localparam logic [15:0] POLY_B  = 16'd42048;
   localparam logic [12:0] POLY_C  = 13'd4640;
   localparam logic [16:0] ONE_Q16 = 17'd65536;

   typedef enum logic [1:0] {
      CSR_TILE_ROWS   = 2'd0,
      CSR_INV_COLUMNS = 2'd1,
      CSR_INV_ROWS    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [8:0]  rows;
      logic [8:0]  rem;
      logic [15:0] quo;
      logic [15:0] dvd;
   } div_type;

   typedef struct packed {
      logic [15:0] size_x;
      logic [15:0] size_y;
      logic [15:0] frac;
      logic [1:0]  quad;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] color;
   } item_type;

   typedef struct packed {
      logic [15:0] col;
      logic [8:0]  row;
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [31:0] color;
   } pass_type;

   typedef struct packed {
      logic signed [34:0] pxc;
      logic signed [34:0] pys;
      logic signed [34:0] pxs;
      logic signed [34:0] pyc;
   } prod_type;

endpackage

// File: src/pbqe_div_cell.sv
module pbqe_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   input  pbqe_pkg::div_type  div_i,
   input  pbqe_pkg::item_type item_i,
   output logic               valid_o,
   output pbqe_pkg::div_type  div_o,
   output pbqe_pkg::item_type item_o
);

   logic [9:0]         trial;
   logic [9:0]         diff;
   logic               ge;
   logic               valid_ff;
   pbqe_pkg::div_type  div_ff;
   pbqe_pkg::div_type  div_in;
   pbqe_pkg::item_type item_ff;

   always_comb begin
      trial       = {div_i.rem, div_i.dvd[15]};
      ge          = trial >= {1'b0, div_i.rows};
      diff        = trial - {1'b0, div_i.rows};
      div_in.rows = div_i.rows;
      div_in.rem  = ge ? diff[8:0] : trial[8:0];
      div_in.quo  = {div_i.quo[14:0], ge};
      div_in.dvd  = {div_i.dvd[14:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_i;
      end
   end

   always_ff @(posedge clock) begin
      div_ff  <= div_in;
      item_ff <= item_i;
   end

   assign valid_o = valid_ff;
   assign div_o   = div_ff;
   assign item_o  = item_ff;

endmodule

// File: src/pbqe_trig.sv
module pbqe_trig (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   input  pbqe_pkg::item_type item_i,
   input  pbqe_pkg::pass_type pass_i,
   output logic               valid_o,
   output pbqe_pkg::prod_type prod_o,
   output pbqe_pkg::pass_type pass_o
);

   localparam int NSTG = 8;

   logic [NSTG-1:0]    valid_ff;
   pbqe_pkg::item_type item_ff [NSTG];
   pbqe_pkg::pass_type pass_ff [NSTG];

   logic [16:0]        arg_ff  [2];
   logic [16:0]        x2_ff   [2];
   logic [16:0]        arg2_ff [2];
   logic [16:0]        x3_ff   [2];
   logic [16:0]        x2b_ff  [2];
   logic [16:0]        arg3_ff [2];
   logic [16:0]        x5_ff   [2];
   logic [33:0]        ta_ff   [2];
   logic [33:0]        tb_ff   [2];
   logic [33:0]        tc_ff   [2];
   logic signed [35:0] d_ff    [2];
   logic [16:0]        sin_ff  [2];
   logic signed [17:0] s_ff;
   logic signed [17:0] c_ff;
   pbqe_pkg::prod_type prod_ff;

   logic [33:0]        m2   [2];
   logic [33:0]        m3   [2];
   logic [33:0]        m5   [2];
   logic signed [35:0] acc  [2];
   logic [16:0]        sin_in [2];
   logic signed [17:0] p_s;
   logic signed [17:0] q_s;
   logic signed [17:0] s_in;
   logic signed [17:0] c_in;
   logic signed [34:0] c_e;
   logic signed [34:0] s_e;
   logic signed [34:0] sx_e;
   logic signed [34:0] sy_e;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         m2[i]  = 34'(arg_ff[i]) * 34'(arg_ff[i]);
         m3[i]  = 34'(x2_ff[i]) * 34'(arg2_ff[i]);
         m5[i]  = 34'(x3_ff[i]) * 34'(x2b_ff[i]);
         acc[i] = d_ff[i] + $signed({2'b00, tc_ff[i]});
         if (acc[i] < 0) begin
            sin_in[i] = 17'd0;
         end else if ((acc[i] >>> 16) > $signed({19'd0, pbqe_pkg::ONE_Q16})) begin
            sin_in[i] = pbqe_pkg::ONE_Q16;
         end else begin
            sin_in[i] = acc[i][32:16];
         end
      end
      p_s = $signed({1'b0, sin_ff[0]});
      q_s = $signed({1'b0, sin_ff[1]});
      case (item_ff[5].quad)
         2'd0: begin
            s_in = p_s;
            c_in = q_s;
         end
         2'd1: begin
            s_in = q_s;
            c_in = -p_s;
         end
         2'd2: begin
            s_in = -p_s;
            c_in = -q_s;
         end
         default: begin
            s_in = -q_s;
            c_in = p_s;
         end
      endcase
      c_e  = {{17{c_ff[17]}}, c_ff};
      s_e  = {{17{s_ff[17]}}, s_ff};
      sx_e = $signed({19'd0, item_ff[6].size_x});
      sy_e = $signed({19'd0, item_ff[6].size_y});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[NSTG-2:0], valid_i};
      end
   end

   always_ff @(posedge clock) begin
      item_ff[0] <= item_i;
      pass_ff[0] <= pass_i;
      for (int j = 1; j < NSTG; j++) begin
         item_ff[j] <= item_ff[j-1];
         pass_ff[j] <= pass_ff[j-1];
      end
      arg_ff[0] <= {1'b0, item_i.frac};
      arg_ff[1] <= pbqe_pkg::ONE_Q16 - {1'b0, item_i.frac};
      for (int i = 0; i < 2; i++) begin
         x2_ff[i]   <= m2[i][32:16];
         arg2_ff[i] <= arg_ff[i];
         x3_ff[i]   <= m3[i][32:16];
         x2b_ff[i]  <= x2_ff[i];
         arg3_ff[i] <= arg2_ff[i];
         x5_ff[i]   <= m5[i][32:16];
         ta_ff[i]   <= 34'(pbqe_pkg::POLY_A) * 34'(arg3_ff[i]);
         tb_ff[i]   <= 34'(pbqe_pkg::POLY_B) * 34'(x3_ff[i]);
         tc_ff[i]   <= 34'(pbqe_pkg::POLY_C) * 34'(x5_ff[i]);
         d_ff[i]    <= $signed({2'b00, ta_ff[i]}) - $signed({2'b00, tb_ff[i]});
         sin_ff[i]  <= sin_in[i];
      end
      s_ff        <= s_in;
      c_ff        <= c_in;
      prod_ff.pxc <= sx_e * c_e;
      prod_ff.pys <= sy_e * s_e;
      prod_ff.pxs <= sx_e * s_e;
      prod_ff.pyc <= sy_e * c_e;
   end

   assign valid_o = valid_ff[NSTG-1];
   assign prod_o  = prod_ff;
   assign pass_o  = pass_ff[NSTG-1];

endmodule

// File: src/pbqe_corner.sv
module pbqe_corner (
   input  logic                clock,
   input  logic                reset,
   input  logic                valid_i,
   input  pbqe_pkg::prod_type  prod_i,
   input  pbqe_pkg::pass_type  pass_i,
   input  logic [16:0]         inv_columns,
   input  logic [16:0]         inv_rows,
   output logic                rsp_valid,
   output logic [1:0]          rsp_corner,
   output logic signed [16:0]  rsp_offset_x,
   output logic signed [16:0]  rsp_offset_y,
   output logic [16:0]         rsp_tex_u,
   output logic [16:0]         rsp_tex_v,
   output logic signed [31:0]  rsp_out_pos_x,
   output logic signed [31:0]  rsp_out_pos_y,
   output logic signed [31:0]  rsp_out_pos_z,
   output logic [31:0]         rsp_out_color,
   output logic                rsp_last
);

   pbqe_pkg::prod_type prod_ff;
   pbqe_pkg::pass_type pass_ff;
   logic               active_ff;
   logic [1:0]         corner_ff;
   logic               valid_ff;
   logic [1:0]         out_corner_ff;
   logic               last_ff;
   logic [16:0]        ox_ff;
   logic [16:0]        oy_ff;
   logic [16:0]        u_ff;
   logic [16:0]        v_ff;
   pbqe_pkg::pass_type out_pass_ff;

   logic signed [36:0] pxc_e, pys_e, pxs_e, pyc_e;
   logic signed [36:0] sum_x, sum_y, tx, ty, shx, shy;
   logic [16:0]        ox_in, oy_in, u_in, v_in;
   logic [16:0]        cu;
   logic [9:0]         rv;
   logic [33:0]        pu;
   logic [26:0]        pv;

   always_comb begin
      pxc_e = {{2{prod_ff.pxc[34]}}, prod_ff.pxc};
      pys_e = {{2{prod_ff.pys[34]}}, prod_ff.pys};
      pxs_e = {{2{prod_ff.pxs[34]}}, prod_ff.pxs};
      pyc_e = {{2{prod_ff.pyc[34]}}, prod_ff.pyc};
      sum_x = (corner_ff[0] ? pxc_e : -pxc_e) + (corner_ff[1] ? pys_e : -pys_e);
      sum_y = (corner_ff[0] ? pxs_e : -pxs_e) + (corner_ff[1] ? -pyc_e : pyc_e);
      tx    = sum_x + 37'sd65536;
      ty    = sum_y + 37'sd65536;
      shx   = tx >>> 17;
      shy   = ty >>> 17;
      if (shx > 37'sd65535) begin
         ox_in = 17'd65535;
      end else if (shx < -37'sd65535) begin
         ox_in = 17'h10001;
      end else begin
         ox_in = shx[16:0];
      end
      if (shy > 37'sd65535) begin
         oy_in = 17'd65535;
      end else if (shy < -37'sd65535) begin
         oy_in = 17'h10001;
      end else begin
         oy_in = shy[16:0];
      end
      cu   = {1'b0, pass_ff.col} + {16'd0, corner_ff[0]};
      rv   = {1'b0, pass_ff.row} + {9'd0, corner_ff[1]};
      pu   = 34'(cu) * 34'(inv_columns);
      pv   = 27'(rv) * 27'(inv_rows);
      u_in = (pu > 34'(pbqe_pkg::ONE_Q16)) ? pbqe_pkg::ONE_Q16 : pu[16:0];
      v_in = (pv > 27'(pbqe_pkg::ONE_Q16)) ? pbqe_pkg::ONE_Q16 : pv[16:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         corner_ff <= 2'd0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= active_ff;
         if (active_ff) begin
            corner_ff <= corner_ff + 2'd1;
            if (corner_ff == 2'd3) begin
               active_ff <= 1'b0;
            end
         end
         if (valid_i) begin
            active_ff <= 1'b1;
            corner_ff <= 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (valid_i) begin
         prod_ff <= prod_i;
         pass_ff <= pass_i;
      end
      out_corner_ff <= corner_ff;
      last_ff       <= corner_ff == 2'd3;
      ox_ff         <= ox_in;
      oy_ff         <= oy_in;
      u_ff          <= u_in;
      v_ff          <= v_in;
      out_pass_ff   <= pass_ff;
   end

   assign rsp_valid     = valid_ff;
   assign rsp_corner    = out_corner_ff;
   assign rsp_offset_x  = $signed(ox_ff);
   assign rsp_offset_y  = $signed(oy_ff);
   assign rsp_tex_u     = u_ff;
   assign rsp_tex_v     = v_ff;
   assign rsp_out_pos_x = $signed(out_pass_ff.pos_x);
   assign rsp_out_pos_y = $signed(out_pass_ff.pos_y);
   assign rsp_out_pos_z = $signed(out_pass_ff.pos_z);
   assign rsp_out_color = out_pass_ff.color;
   assign rsp_last      = last_ff;

endmodule

// File: src/particle_billboard_quad_expander.sv
// channel   ports                          transfer when
// request   start, busy, req_*             start high and busy low
// response  rsp_valid, rsp_*               rsp_valid high, one cycle each
// config    csr_we, csr_index, csr_data    csr_we high
//
// Busy stays high after each transfer, set by the four corners leaving on
// the one response port; no new particle is taken while busy is high.
// Corner 0 follows the transfer through 16 divider cells for tile div rows,
// then an 8 stage sine and product pipeline; corners follow
// on consecutive cycles. Synchronous reset clears the pipeline and restores
// the register defaults. The receiver cannot stall the response port.
module particle_billboard_quad_expander #(
   parameter int ANGLE_BITS    = 16,
   parameter int MAX_TILE_ROWS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [15:0]        req_size_x,
   input  logic [15:0]        req_size_y,
   input  logic [15:0]        req_spin,
   input  logic [15:0]        req_tile,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_color,
   output logic               rsp_valid,
   output logic [1:0]         rsp_corner,
   output logic signed [16:0] rsp_offset_x,
   output logic signed [16:0] rsp_offset_y,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic signed [31:0] rsp_out_pos_x,
   output logic signed [31:0] rsp_out_pos_y,
   output logic signed [31:0] rsp_out_pos_z,
   output logic [31:0]        rsp_out_color,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data
);

   localparam int FRAC_BITS = ANGLE_BITS - 2;
   localparam int NCELL     = pbqe_pkg::TILE_BITS;

   logic [8:0]  tile_rows_ff;
   logic [16:0] inv_columns_ff;
   logic [16:0] inv_rows_ff;
   logic [1:0]  hold_ff;
   logic        accept;
   logic [23:0] spin_wide;
   logic [ANGLE_BITS-1:0] angle;
   logic [15:0] frac16;
   logic [8:0]  rows_sel;

   logic               valid_c [NCELL+1];
   pbqe_pkg::div_type  div_c   [NCELL+1];
   pbqe_pkg::item_type item_c  [NCELL+1];
   pbqe_pkg::pass_type pass_t;
   logic               trig_valid;
   pbqe_pkg::prod_type trig_prod;
   pbqe_pkg::pass_type trig_pass;

   assign busy      = hold_ff != 2'd0;
   assign accept    = start && !busy;
   assign spin_wide = 24'(req_spin);
   assign angle     = spin_wide[ANGLE_BITS-1:0];

   generate
      if (FRAC_BITS >= 16) begin : g_frac_cut
         assign frac16 = angle[FRAC_BITS-1 -: 16];
      end else begin : g_frac_pad
         assign frac16 = {angle[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
      end
   endgenerate

   always_comb begin
      if (tile_rows_ff == 9'd0) begin
         rows_sel = 9'd1;
      end else if (32'(tile_rows_ff) > MAX_TILE_ROWS) begin
         rows_sel = 9'(MAX_TILE_ROWS);
      end else begin
         rows_sel = tile_rows_ff;
      end
      valid_c[0]       = accept;
      div_c[0].rows    = rows_sel;
      div_c[0].rem     = 9'd0;
      div_c[0].quo     = 16'd0;
      div_c[0].dvd     = req_tile;
      item_c[0].size_x = req_size_x;
      item_c[0].size_y = req_size_y;
      item_c[0].frac   = frac16;
      item_c[0].quad   = angle[ANGLE_BITS-1 -: 2];
      item_c[0].pos_x  = req_pos_x;
      item_c[0].pos_y  = req_pos_y;
      item_c[0].pos_z  = req_pos_z;
      item_c[0].color  = req_color;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_rows_ff   <= 9'd1;
         inv_columns_ff <= 17'd65536;
         inv_rows_ff    <= 17'd65536;
         hold_ff        <= 2'd0;
      end else begin
         if (accept) begin
            hold_ff <= 2'd3;
         end else if (hold_ff != 2'd0) begin
            hold_ff <= hold_ff - 2'd1;
         end
         if (csr_we) begin
            case (pbqe_pkg::csr_index_type'(csr_index))
               pbqe_pkg::CSR_TILE_ROWS:   tile_rows_ff   <= csr_data[8:0];
               pbqe_pkg::CSR_INV_COLUMNS: inv_columns_ff <= csr_data;
               pbqe_pkg::CSR_INV_ROWS:    inv_rows_ff    <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   generate
      for (genvar i = 0; i < NCELL; i++) begin : g_cell
         pbqe_div_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .valid_i (valid_c[i]),
            .div_i   (div_c[i]),
            .item_i  (item_c[i]),
            .valid_o (valid_c[i+1]),
            .div_o   (div_c[i+1]),
            .item_o  (item_c[i+1])
         );
      end
   endgenerate

   always_comb begin
      pass_t.col   = div_c[NCELL].quo;
      pass_t.row   = div_c[NCELL].rem;
      pass_t.pos_x = item_c[NCELL].pos_x;
      pass_t.pos_y = item_c[NCELL].pos_y;
      pass_t.pos_z = item_c[NCELL].pos_z;
      pass_t.color = item_c[NCELL].color;
   end

   pbqe_trig u_trig (
      .clock   (clock),
      .reset   (reset),
      .valid_i (valid_c[NCELL]),
      .item_i  (item_c[NCELL]),
      .pass_i  (pass_t),
      .valid_o (trig_valid),
      .prod_o  (trig_prod),
      .pass_o  (trig_pass)
   );

   pbqe_corner u_corner (
      .clock         (clock),
      .reset         (reset),
      .valid_i       (trig_valid),
      .prod_i        (trig_prod),
      .pass_i        (trig_pass),
      .inv_columns   (inv_columns_ff),
      .inv_rows      (inv_rows_ff),
      .rsp_valid     (rsp_valid),
      .rsp_corner    (rsp_corner),
      .rsp_offset_x  (rsp_offset_x),
      .rsp_offset_y  (rsp_offset_y),
      .rsp_tex_u     (rsp_tex_u),
      .rsp_tex_v     (rsp_tex_v),
      .rsp_out_pos_x (rsp_out_pos_x),
      .rsp_out_pos_y (rsp_out_pos_y),
      .rsp_out_pos_z (rsp_out_pos_z),
      .rsp_out_color (rsp_out_color),
      .rsp_last      (rsp_last)
   );

`ifndef ASSERT_OFF
   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_corner != 2'd0 |->
         $past(rsp_valid) && rsp_corner == 2'($past(rsp_corner) + 2'd1))
      else $error("corner out of order");

   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after transfer");

   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last |-> rsp_valid && rsp_corner == 2'd3)
      else $error("last outside corner three");
`endif

endmodule

// File: tb/sv/particle_billboard_quad_expander_checker.sv
`timescale 1ns / 1ps

module particle_billboard_quad_expander_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [15:0]        req_size_x,
   input  logic [15:0]        req_size_y,
   input  logic [15:0]        req_spin,
   input  logic [15:0]        req_tile,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_color,
   input  logic               rsp_valid,
   input  logic [1:0]         rsp_corner,
   input  logic signed [16:0] rsp_offset_x,
   input  logic signed [16:0] rsp_offset_y,
   input  logic [16:0]        rsp_tex_u,
   input  logic [16:0]        rsp_tex_v,
   input  logic signed [31:0] rsp_out_pos_x,
   input  logic signed [31:0] rsp_out_pos_y,
   input  logic signed [31:0] rsp_out_pos_z,
   input  logic [31:0]        rsp_out_color,
   input  logic               rsp_last,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [16:0]        csr_data,
   output int                 pending,
   output int                 failures
);

   localparam longint MAX_ROWS = 256;
   localparam longint OFS_LIMIT = 65535;

   typedef struct {
      logic [1:0]         corner;
      logic signed [16:0] offset_x;
      logic signed [16:0] offset_y;
      logic [16:0]        tex_u;
      logic [16:0]        tex_v;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [31:0]        color;
      logic               last;
   } vertex_type;

   vertex_type vertex_q[$];
   logic [8:0]  tile_rows_reg;
   logic [16:0] inv_cols_reg;
   logic [16:0] inv_rows_reg;

   assign pending = vertex_q.size();

   function automatic longint sine_quarter(longint x);
      longint x2, x3, x5, acc;
      x2 = (x * x) >>> 16;
      x3 = (x2 * x) >>> 16;
      x5 = (x3 * x2) >>> 16;
      acc = 102944 * x - 42048 * x3 + 4640 * x5;
      if (acc < 0) acc = 0;
      acc = acc >>> 16;
      if (acc > 65536) acc = 65536;
      return acc;
   endfunction

   function automatic logic signed [16:0] corner_offset(longint prod_sum);
      longint r;
      r = (prod_sum + 65536) >>> 17;
      if (r > OFS_LIMIT) r = OFS_LIMIT;
      if (r < -OFS_LIMIT) r = -OFS_LIMIT;
      return r[16:0];
   endfunction

   function automatic logic [16:0] tex_coord(longint idx, longint inv);
      longint t;
      t = idx * inv;
      if (t > 65536) t = 65536;
      return t[16:0];
   endfunction

   task automatic expand_particle();
      longint sx, sy, x, p, q, s, c, rows, col, row, a, b;
      vertex_type v;
      sx = req_size_x;
      sy = req_size_y;
      x = longint'(req_spin[13:0]) << 2;
      p = sine_quarter(x);
      q = sine_quarter(65536 - x);
      case (req_spin[15:14])
         2'd0: begin s = p;  c = q;  end
         2'd1: begin s = q;  c = -p; end
         2'd2: begin s = -p; c = -q; end
         default: begin s = -q; c = p; end
      endcase
      rows = tile_rows_reg;
      if (rows == 0) rows = 1;
      if (rows > MAX_ROWS) rows = MAX_ROWS;
      col = req_tile / rows;
      row = req_tile % rows;
      for (int k = 0; k < 4; k++) begin
         a = k[0] ? 1 : -1;
         b = k[1] ? -1 : 1;
         v.corner = k[1:0];
         v.offset_x = corner_offset(a * sx * c - b * sy * s);
         v.offset_y = corner_offset(a * sx * s + b * sy * c);
         v.tex_u = tex_coord(col + k[0], inv_cols_reg);
         v.tex_v = tex_coord(row + k[1], inv_rows_reg);
         v.pos_x = req_pos_x;
         v.pos_y = req_pos_y;
         v.pos_z = req_pos_z;
         v.color = req_color;
         v.last = (k == 3);
         vertex_q.push_back(v);
      end
   endtask

   task automatic compare_vertex();
      vertex_type v;
      if (vertex_q.size() == 0) begin
         $error("vertex with no particle outstanding, corner %0d", rsp_corner);
         failures++;
         return;
      end
      v = vertex_q.pop_front();
      if (rsp_corner !== v.corner) begin
         $error("corner expected %0d actual %0d", v.corner, rsp_corner); failures++;
      end
      if (rsp_offset_x !== v.offset_x) begin
         $error("offset_x expected %0d actual %0d", v.offset_x, rsp_offset_x); failures++;
      end
      if (rsp_offset_y !== v.offset_y) begin
         $error("offset_y expected %0d actual %0d", v.offset_y, rsp_offset_y); failures++;
      end
      if (rsp_tex_u !== v.tex_u) begin
         $error("tex_u expected %0d actual %0d", v.tex_u, rsp_tex_u); failures++;
      end
      if (rsp_tex_v !== v.tex_v) begin
         $error("tex_v expected %0d actual %0d", v.tex_v, rsp_tex_v); failures++;
      end
      if (rsp_out_pos_x !== v.pos_x) begin
         $error("out_pos_x expected %0d actual %0d", v.pos_x, rsp_out_pos_x); failures++;
      end
      if (rsp_out_pos_y !== v.pos_y) begin
         $error("out_pos_y expected %0d actual %0d", v.pos_y, rsp_out_pos_y); failures++;
      end
      if (rsp_out_pos_z !== v.pos_z) begin
         $error("out_pos_z expected %0d actual %0d", v.pos_z, rsp_out_pos_z); failures++;
      end
      if (rsp_out_color !== v.color) begin
         $error("out_color expected %h actual %h", v.color, rsp_out_color); failures++;
      end
      if (rsp_last !== v.last) begin
         $error("last expected %0d actual %0d", v.last, rsp_last); failures++;
      end
   endtask

   initial failures = 0;

   always @(posedge clock) begin
      if (reset) begin
         tile_rows_reg <= 9'd1;
         inv_cols_reg <= 17'd65536;
         inv_rows_reg <= 17'd65536;
         vertex_q.delete();
      end else begin
         if (rsp_valid === 1'b1) compare_vertex();
         if (start && !busy) expand_particle();
         if (csr_we) begin
            case (csr_index)
               pbqe_pkg::CSR_TILE_ROWS:   tile_rows_reg <= csr_data[8:0];
               pbqe_pkg::CSR_INV_COLUMNS: inv_cols_reg <= csr_data;
               pbqe_pkg::CSR_INV_ROWS:    inv_rows_reg <= csr_data;
               default: ;
            endcase
         end
      end
   end

endmodule

// File: tb/sv/particle_billboard_quad_expander_tb.sv
`timescale 1ns / 1ps

module particle_billboard_quad_expander_tb;

   localparam logic [1:0] CSR_UNUSED = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [15:0]        req_size_x = '0;
   logic [15:0]        req_size_y = '0;
   logic [15:0]        req_spin = '0;
   logic [15:0]        req_tile = '0;
   logic signed [31:0] req_pos_x = '0;
   logic signed [31:0] req_pos_y = '0;
   logic signed [31:0] req_pos_z = '0;
   logic [31:0]        req_color = '0;
   logic               rsp_valid;
   logic [1:0]         rsp_corner;
   logic signed [16:0] rsp_offset_x;
   logic signed [16:0] rsp_offset_y;
   logic [16:0]        rsp_tex_u;
   logic [16:0]        rsp_tex_v;
   logic signed [31:0] rsp_out_pos_x;
   logic signed [31:0] rsp_out_pos_y;
   logic signed [31:0] rsp_out_pos_z;
   logic [31:0]        rsp_out_color;
   logic               rsp_last;
   logic               csr_we = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [16:0]        csr_data = '0;
   int                 pending;
   int                 failures;

   always #5 clock = ~clock;

   particle_billboard_quad_expander dut (.*);

   particle_billboard_quad_expander_checker checker_i (.*);

   task automatic write_csr(logic [1:0] idx, logic [16:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
   endtask

   task automatic set_atlas(logic [8:0] rows, logic [16:0] inv_cols, logic [16:0] inv_rows);
      start <= 1'b0;
      wait (pending == 0);
      repeat (30) @(negedge clock);
      write_csr(pbqe_pkg::CSR_TILE_ROWS, {8'd0, rows});
      write_csr(pbqe_pkg::CSR_INV_COLUMNS, inv_cols);
      write_csr(pbqe_pkg::CSR_INV_ROWS, inv_rows);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic send_particle(logic [15:0] sx, logic [15:0] sy, logic [15:0] spin,
                                logic [15:0] tile, logic [31:0] px, logic [31:0] py,
                                logic [31:0] pz, logic [31:0] color);
      int gap;
      req_size_x <= sx;
      req_size_y <= sy;
      req_spin <= spin;
      req_tile <= tile;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_color <= color;
      start <= 1'b1;
      #1;
      while (busy) @(negedge clock);
      @(negedge clock);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic send_random();
      logic [15:0] sx, sy;
      sx = 16'($urandom);
      sy = 16'($urandom);
      case ($urandom_range(0, 5))
         0: sx = 16'hFFFF;
         1: sy = 16'hFFFF;
         2: sx = 16'($urandom_range(0, 1024));
         default: ;
      endcase
      send_particle(sx, sy, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom,
                    $urandom);
   endtask

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_particle(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                    32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0);
      send_particle(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF,
                    32'h7FFFFFFF, 32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send_particle(16'hFFFF, 16'hFFFF, 16'h4000, 16'h0001, 1, -1, 0, 32'h12345678);
      send_particle(16'hFFFF, 16'h0100, 16'h8000, 16'h0002, 0, 0, 0, 0);
      send_particle(16'h0100, 16'hFFFF, 16'hC000, 16'h0003, 0, 0, 0, 0);
      send_particle(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0004, 0, 0, 0, 0);
      send_particle(16'hFFFF, 16'hFFFF, 16'h2000, 16'h0005, 0, 0, 0, 0);
      send_particle(16'h0001, 16'h0001, 16'h3FFF, 16'h0006, 0, 0, 0, 0);

      set_atlas(9'd0, 17'd0, 17'd131071);
      write_csr(CSR_UNUSED, 17'h1FFFF);
      csr_we <= 1'b0;
      @(negedge clock);
      send_particle(16'h0200, 16'h0300, 16'h6000, 16'hFFFF, 0, 0, 0, 0);
      send_particle(16'h0200, 16'h0300, 16'hA000, 16'h0000, 0, 0, 0, 0);

      set_atlas(9'd511, 17'd131071, 17'd1);
      send_particle(16'h0400, 16'h0400, 16'h1234, 16'hFFFF, 0, 0, 0, 0);
      send_particle(16'h0400, 16'h0400, 16'h1234, 16'h00FF, 0, 0, 0, 0);

      set_atlas(9'd256, 17'd256, 17'd256);
      send_particle(16'h0400, 16'h0400, 16'h5555, 16'hFFFF, 0, 0, 0, 0);
      send_particle(16'h0400, 16'h0400, 16'hAAAA, 16'h0100, 0, 0, 0, 0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: set_atlas(9'd1, 17'd65536, 17'd65536);
            1: set_atlas(9'd16, 17'd4096, 17'd4096);
            default: set_atlas(9'($urandom_range(0, 511)), 17'($urandom_range(0, 131071)),
                               17'($urandom_range(0, 65536)));
         endcase
         for (int n = 0; n < 40; n++) send_random();
      end

      start <= 1'b0;
      wait (pending == 0);
      repeat (40) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
